// ===== rtl/tcta_pkg.sv =====
// ----------------------------------------------------------------------------
// tcta_pkg
// Shared types and codes for the two-class transmit arbiter.
// ----------------------------------------------------------------------------
package tcta_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_W           = 32;
    localparam int MODE_W          = 2;

    // retrieval modes; the upper mode bit selects in-order operation
    localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK_PRIO    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IN_ORDER    = 2'd2;
    localparam int                MODE_IN_ORDER_BIT = 1;

    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_RETRIEVE = 1'b1;

    typedef struct packed {
        logic             func;
        logic             packet_is_ack;
        logic [TAG_W-1:0] packet_tag;
    } t_in_item;

    typedef struct packed {
        logic             got_packet;
        logic [TAG_W-1:0] out_tag;
        logic             from_ack_queue;
        logic             add_dropped;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctrl;

endpackage

// ===== rtl/two_class_transmit_arbiter.sv =====
// ----------------------------------------------------------------------------
// two_class_transmit_arbiter
// Ack and data handle FIFOs served by round robin, ack priority or in order.
// ----------------------------------------------------------------------------
//  channel   signals                             direction
//  input     i_in_valid / o_in_ready / i_in_data     in   add or retrieve request
//  output    o_out_valid / i_out_ready / o_out_data  out  one result per request
//  config    i_cfg_valid / o_cfg_ready / i_cfg_data  in   retrieval mode
//
//  One request per cycle while the output is not stalled. A request passes an
//  input register, then the result register, with FIFO head reads prefetched from the next head slot.
//  Synchronous active-low reset empties both FIFOs and clears the mode and
//  the round-robin toggle. A stalled output holds the result; the input
//  register then fills and o_in_ready drops.
// ----------------------------------------------------------------------------
module two_class_transmit_arbiter
    import tcta_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_in_item          r_in;
    logic              r_in_vld;
    t_out_item         r_out;
    t_out_item         n_out;
    logic              r_out_vld;
    logic [MODE_W-1:0] r_mode;
    logic              r_rr;

    logic              advance;
    logic              in_accept;
    logic              in_order;
    logic              is_add;
    logic              to_data;
    logic              drop;
    logic              have_ack;
    logic              have_data;
    logic              pick_ack;
    logic              pick_data;
    logic              rr_toggle;
    t_fifo_ctrl        ack_ctrl;
    t_fifo_ctrl        data_ctrl;
    logic [CW-1:0]     ack_count;
    logic [CW-1:0]     data_count;
    logic [TAG_W-1:0]  ack_head;
    logic [TAG_W-1:0]  data_head;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    assign in_order  = r_mode[MODE_IN_ORDER_BIT];
    assign is_add    = (r_in.func == FUNC_ADD);
    assign to_data   = in_order || !r_in.packet_is_ack;
    assign have_ack  = (ack_count != '0);
    assign have_data = (data_count != '0);

    always_comb begin
        pick_ack  = 1'b0;
        pick_data = 1'b0;
        rr_toggle = 1'b0;
        drop      = is_add && (to_data ? (data_count == CW'(QUEUE_DEPTH))
                                       : (ack_count == CW'(QUEUE_DEPTH)));
        if (!is_add) begin
            priority if (in_order) begin
                pick_data = have_data;
            end else if (r_mode == MODE_ACK_PRIO) begin
                pick_ack  = have_ack;
                pick_data = !have_ack && have_data;
            end else if (have_ack && have_data) begin
                // a clear flag serves acks, then the flag toggles
                rr_toggle = 1'b1;
                pick_ack  = !r_rr;
                pick_data = r_rr;
            end else begin
                pick_ack  = have_ack;
                pick_data = have_data;
            end
        end

        ack_ctrl.push  = advance && is_add && !to_data && !drop;
        ack_ctrl.pop   = advance && pick_ack;
        data_ctrl.push = advance && is_add && to_data && !drop;
        data_ctrl.pop  = advance && pick_data;

        n_out.got_packet     = pick_ack || pick_data;
        n_out.out_tag        = pick_ack ? ack_head : (pick_data ? data_head : '0);
        n_out.from_ack_queue = pick_ack;
        n_out.add_dropped    = drop;
    end

    tcta_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ack_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ack_ctrl),
        .i_data      (r_in.packet_tag),
        .o_count     (ack_count),
        .o_head_data (ack_head)
    );

    tcta_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_data_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (data_ctrl),
        .i_data      (r_in.packet_tag),
        .o_count     (data_count),
        .o_head_data (data_head)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode    <= MODE_ROUND_ROBIN;
            r_rr      <= 1'b0;
        end else begin
            r_in_vld  <= in_accept || (r_in_vld && !advance);
            r_out_vld <= advance || (r_out_vld && !i_out_ready);
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (advance && rr_toggle) begin
                r_rr <= !r_rr;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/tcta_fifo.sv =====
// ----------------------------------------------------------------------------
// tcta_fifo
// Circular FIFO of packet handles with the head entry held in a register.
// ----------------------------------------------------------------------------
module tcta_fifo
    import tcta_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_fifo_ctrl                 i_ctrl,
    input  logic [TAG_W-1:0]           i_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [TAG_W-1:0]           o_head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [TAG_W-1:0] r_mem [DEPTH];
    logic [TAG_W-1:0] r_rd_data;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_head;
    logic [AW-1:0]    n_tail;
    logic [CW-1:0]    n_count;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb begin
        n_head  = i_ctrl.pop  ? wrap_inc(r_head) : r_head;
        n_tail  = i_ctrl.push ? wrap_inc(r_tail) : r_tail;
        n_count = r_count;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_data;
        end
        // read ahead at the next head; a write to that slot bypasses the array
        if (i_ctrl.push && (r_tail == n_head)) begin
            r_rd_data <= i_data;
        end else begin
            r_rd_data <= r_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_count     = r_count;
    assign o_head_data = r_rd_data;

endmodule

// ===== tb/tb_two_class_transmit_arbiter.sv =====
// ----------------------------------------------------------------------------
// tb_two_class_transmit_arbiter
// Drives add and retrieve requests through the arbiter under every retrieval
// mode, with random gaps on the input and random stalls on the output, and
// checks each result against a behavioral copy of the two handle FIFOs.
// ----------------------------------------------------------------------------
module tb_two_class_transmit_arbiter;
    import tcta_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    // unused encoding, upper bit set: served like in-order mode
    localparam logic [MODE_W-1:0] MODE_IN_ORDER_ALT = MODE_IN_ORDER | MODE_ACK_PRIO;
    localparam int PHASES = 8;
    localparam int PHASE_LEN = 50;

    class arbiter_scoreboard;
        typedef enum {SERVE_NONE, SERVE_ACK, SERVE_DATA} t_serve;

        logic [TAG_W-1:0]  ack_handles[$];
        logic [TAG_W-1:0]  data_handles[$];
        t_out_item         pending_results[$];
        logic              rr_serve_ack;
        logic [MODE_W-1:0] mode;
        int                errors;

        function new();
            rr_serve_ack = 1'b0;
            mode = MODE_ROUND_ROBIN;
            errors = 0;
        endfunction

        function void note_request(t_in_item req);
            t_out_item res;
            t_serve    serve;
            logic      in_order;
            res = '0;
            serve = SERVE_NONE;
            in_order = mode[MODE_IN_ORDER_BIT];
            if (req.func == FUNC_ADD) begin
                if (in_order || !req.packet_is_ack) begin
                    if (data_handles.size() >= DEPTH) res.add_dropped = 1'b1;
                    else data_handles.push_back(req.packet_tag);
                end else begin
                    if (ack_handles.size() >= DEPTH) res.add_dropped = 1'b1;
                    else ack_handles.push_back(req.packet_tag);
                end
            end else begin
                if (in_order) begin
                    if (data_handles.size() != 0) serve = SERVE_DATA;
                end else if (mode == MODE_ACK_PRIO) begin
                    if (ack_handles.size() != 0) serve = SERVE_ACK;
                    else if (data_handles.size() != 0) serve = SERVE_DATA;
                end else begin
                    // toggle only moves when both classes are waiting
                    if (ack_handles.size() != 0 && data_handles.size() != 0) begin
                        rr_serve_ack = ~rr_serve_ack;
                        serve = rr_serve_ack ? SERVE_ACK : SERVE_DATA;
                    end else if (ack_handles.size() != 0) begin
                        serve = SERVE_ACK;
                    end else if (data_handles.size() != 0) begin
                        serve = SERVE_DATA;
                    end
                end
                if (serve == SERVE_ACK) begin
                    res.got_packet = 1'b1;
                    res.out_tag = ack_handles.pop_front();
                    res.from_ack_queue = 1'b1;
                end else if (serve == SERVE_DATA) begin
                    res.got_packet = 1'b1;
                    res.out_tag = data_handles.pop_front();
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.got_packet !== want.got_packet) begin
                $display("%0t: got_packet expected %b actual %b",
                         $time, want.got_packet, got.got_packet);
                errors++;
            end
            if (got.out_tag !== want.out_tag) begin
                $display("%0t: out_tag expected %h actual %h",
                         $time, want.out_tag, got.out_tag);
                errors++;
            end
            if (got.from_ack_queue !== want.from_ack_queue) begin
                $display("%0t: from_ack_queue expected %b actual %b",
                         $time, want.from_ack_queue, got.from_ack_queue);
                errors++;
            end
            if (got.add_dropped !== want.add_dropped) begin
                $display("%0t: add_dropped expected %b actual %b",
                         $time, want.add_dropped, got.add_dropped);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_item          in_data;
    logic              out_valid;
    logic              out_ready;
    t_out_item         out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [MODE_W-1:0] cfg_data;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    arbiter_scoreboard sb = new();

    two_class_transmit_arbiter #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_in_item make_request(logic func, logic is_ack,
                                              logic [TAG_W-1:0] tag);
        t_in_item req;
        req.func = func;
        req.packet_is_ack = is_ack;
        req.packet_tag = tag;
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    // called at a falling edge right after the last request went in
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drains every result first, so the block is idle when the mode is written
    task automatic write_mode(input logic [MODE_W-1:0] m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge i_clk); while (!cfg_ready);
        sb.mode = m;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // result sink with random back-pressure
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            sb.check_result(out_data);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [MODE_W-1:0] phase_mode[PHASES];
        int                add_pct;
        t_in_item          req;

        phase_mode = '{MODE_ROUND_ROBIN, MODE_ACK_PRIO, MODE_IN_ORDER, MODE_IN_ORDER_ALT,
                       MODE_ROUND_ROBIN, MODE_ACK_PRIO, MODE_ROUND_ROBIN, MODE_IN_ORDER};
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // round robin after reset: empty retrieve, extreme tags, toggle
        send_request(make_request(FUNC_RETRIEVE, 1'b0, '0));
        send_request(make_request(FUNC_ADD, 1'b0, 32'h0000_0000));
        send_request(make_request(FUNC_ADD, 1'b1, 32'hFFFF_FFFF));
        send_request(make_request(FUNC_ADD, 1'b0, 32'hFFFF_FFFF));
        send_request(make_request(FUNC_ADD, 1'b1, 32'h0000_0000));
        repeat (5) send_request(make_request(FUNC_RETRIEVE, 1'b1, 32'hFFFF_FFFF));

        // ack priority: an ack is served ahead of waiting data
        write_mode(MODE_ACK_PRIO);
        send_request(make_request(FUNC_ADD, 1'b1, 32'h2222_2222));
        send_request(make_request(FUNC_ADD, 1'b1, 32'h3333_3333));
        send_request(make_request(FUNC_ADD, 1'b0, 32'h1111_1111));
        send_request(make_request(FUNC_RETRIEVE, 1'b0, '0));

        // in order: one ack stays stranded, ack-class adds go to data
        write_mode(MODE_IN_ORDER);
        send_request(make_request(FUNC_RETRIEVE, 1'b0, '0));
        send_request(make_request(FUNC_RETRIEVE, 1'b0, '0));
        send_request(make_request(FUNC_ADD, 1'b1, 32'h4444_4444));
        send_request(make_request(FUNC_RETRIEVE, 1'b0, '0));

        write_mode(MODE_IN_ORDER_ALT);
        send_request(make_request(FUNC_RETRIEVE, 1'b0, '0));

        for (int p = 0; p < PHASES; p++) begin
            write_mode(phase_mode[p]);
            case ($urandom_range(0, 2))
                0: add_pct = 25;
                1: add_pct = 50;
                default: add_pct = 85;
            endcase
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                req.func = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_RETRIEVE;
                req.packet_is_ack = 1'($urandom_range(0, 1));
                req.packet_tag = $urandom();
                send_request(req);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== two_class_transmit_arbiter.f =====
rtl/tcta_pkg.sv
rtl/tcta_fifo.sv
rtl/two_class_transmit_arbiter.sv
tb/tb_two_class_transmit_arbiter.sv
